[sv/bta_pkg.sv]
// bta_pkg: shared types and constants for the buddy allocator tree bitmap
// no dependencies, imported by the allocator and the checker

package bta_pkg;

  // tree geometry
  localparam int unsigned TREE_LEVELS = 10;
  localparam int unsigned NODE_W      = TREE_LEVELS;
  localparam int unsigned NODE_SLOTS  = 1 << TREE_LEVELS;
  localparam int unsigned LVL_W       = $clog2(TREE_LEVELS + 1);

  // configuration registers
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_LOG2 = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LOG2  = CFG_IDX_W'(1);
  localparam logic [4:0] HEAP_LOG2_RST = 5'd15;
  localparam logic [4:0] MIN_LOG2_RST  = 5'd6;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REALLOC = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OFFSET    = 2'd0,
    ST_FAIL      = 2'd1,
    ST_NO_OFFSET = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] request_size;
    logic [31:0] block_offset;
    logic        offset_present;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [30:0] result_offset;
    logic [31:0] old_block_size;
  } res_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISP,
    S_KLEN,
    S_FIND_RD,
    S_FIND_CHK,
    S_ALLOC,
    S_ANC_RD,
    S_ANC_CHK,
    S_SUB_RD,
    S_SUB_CHK,
    S_NEXT,
    S_DONE
  } state_e;

endpackage

[sv/buddy_allocator_tree_bitmap.sv]
// buddy_allocator_tree_bitmap: buddy allocator over a heap-ordered tree of allocated bits
// depends on bta_pkg and bta_ram (the tree bitmap, one bit per node)
// flow: accept, dispatch, size the request, then probe tree bits one by one
//   through the single read port; free tries unaligned and aligned levels from the top down,
//   allocate reads per candidate each ancestor and subtree bit, then the result is reported
// throughput: one item at a time, one result strobe per item, the receiver cannot stall
// reset and every write to a known register start a clearing pass over every tree bit, busy high

module buddy_allocator_tree_bitmap (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  bta_pkg::req_t             req_i,
  output logic                      done_o,
  output bta_pkg::res_t             res_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [bta_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]               cfg_data_i
);

  import bta_pkg::*;

  state_e state_q, state_d;
  logic [4:0]  heap_q, heap_d, min_q, min_d;
  logic [1:0]  op_q, op_d;
  logic [31:0] size_q, size_d, off_q, off_d, v_q, v_d;
  logic        pres_q, pres_d;
  logic [5:0]  k_q, k_d, c_q, c_d;
  logic        found_v_q, found_v_d;
  logic [NODE_W-1:0] found_q, found_d;
  logic [4:0]  lg_q, lg_d;
  logic [NODE_W-1:0] start_q, start_d, cur_q, cur_d, anc_q, anc_d;
  logic        first_v_q, first_v_d;
  logic [NODE_W-1:0] first_q, first_d, base_q, base_d, j_q, j_d, clr_q, clr_d;
  logic [LVL_W-1:0]  t_q, t_d;
  logic        buddy_q, buddy_d;
  res_t        res_q, res_d;

  // bitmap RAM port
  logic              mem_we, mem_wdata, mem_rdata;
  logic [NODE_W-1:0] mem_waddr, mem_raddr;

  bta_ram #(.WIDTH(1), .DEPTH(NODE_SLOTS)) u_tree (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // effective geometry
  logic       geo_ok;
  logic [5:0] h_eff, m_eff, span;
  assign geo_ok = min_q <= heap_q;
  assign h_eff  = 6'(heap_q);
  assign span   = 6'(heap_q) - 6'(min_q) + 6'd1;
  assign m_eff  = (span > 6'(TREE_LEVELS)) ? (6'(heap_q) + 6'd1 - 6'(TREE_LEVELS))
                                           : 6'(min_q);

  // helpers for the find and subtree walks
  logic              in_heap, aligned;
  logic [31:0]       off_sh, sub_addr_w;
  logic [NODE_W-1:0] find_node, sub_addr, sub_last;
  logic [LVL_W-1:0]  times;
  logic [5:0]        kk;
  assign in_heap   = (off_q >> h_eff[4:0]) == 32'd0 || h_eff == 6'd32;
  assign aligned   = (off_q & ((32'd1 << c_q[4:0]) - 32'd1)) == 32'd0;
  assign off_sh    = off_q >> c_q[4:0];
  assign find_node = (NODE_W'(1) << (h_eff - c_q)) + off_sh[NODE_W-1:0];
  assign sub_addr_w = 32'(base_q << t_q) + 32'(j_q);
  assign sub_addr  = sub_addr_w[NODE_W-1:0];
  assign sub_last  = (NODE_W'(1) << t_q) - NODE_W'(1);
  assign times     = LVL_W'(k_q - m_eff);
  assign kk        = (k_q < m_eff) ? m_eff : k_q;

  // next state, datapath and bitmap access
  always_comb begin
    logic              succ, afail, fdone, fhit;
    logic [NODE_W-1:0] pick;
    logic [31:0]       roff;
    succ = 1'b0; afail = 1'b0; fdone = 1'b0; fhit = 1'b0;
    pick = '0; roff = '0;
    state_d = state_q; heap_d = heap_q; min_d = min_q;
    op_d = op_q; size_d = size_q; off_d = off_q; pres_d = pres_q; v_d = v_q;
    k_d = k_q; c_d = c_q; found_v_d = found_v_q; found_d = found_q; lg_d = lg_q;
    start_d = start_q; cur_d = cur_q; anc_d = anc_q; first_v_d = first_v_q;
    first_d = first_q; base_d = base_q; j_d = j_q; t_d = t_q; buddy_d = buddy_q;
    clr_d = clr_q; res_d = res_q;
    mem_we = 1'b0; mem_waddr = '0; mem_wdata = 1'b0; mem_raddr = '0;

    case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr_q;
        clr_d = clr_q + NODE_W'(1);
        if (clr_q == {NODE_W{1'b1}}) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          op_d = req_i.opcode;
          size_d = req_i.request_size;
          off_d = req_i.block_offset;
          pres_d = req_i.offset_present;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        found_v_d = 1'b0;
        c_d = h_eff;
        v_d = size_q - 32'd1;
        k_d = '0;
        res_d.status = ST_FAIL;
        res_d.result_offset = '0;
        res_d.old_block_size = '0;
        state_d = S_DONE;
        if (geo_ok) begin
          case (op_q)
            OP_ALLOC: begin
              if (size_q != 32'd0) state_d = S_KLEN;
            end
            OP_FREE: begin
              if (pres_q && in_heap) state_d = S_FIND_RD;
            end
            OP_REALLOC: begin
              if (!(pres_q && !in_heap)) begin
                if (size_q != 32'd0) begin
                  state_d = S_KLEN;
                end else if (pres_q) begin
                  state_d = S_FIND_RD;
                end else begin
                  res_d.status = ST_NO_OFFSET;
                end
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      // bit length of size - 1, one bit a cycle
      S_KLEN: begin
        if (v_q != 32'd0) begin
          v_d = v_q >> 1;
          k_d = k_q + 6'd1;
        end else if (kk > h_eff) begin
          state_d = S_DONE;
        end else begin
          k_d = kk;
          state_d = (op_q == OP_ALLOC || !pres_q) ? S_ALLOC : S_FIND_RD;
        end
      end
      // search from the top level down for the block at the offset
      S_FIND_RD: begin
        mem_raddr = find_node;
        if (aligned) begin
          state_d = S_FIND_CHK;
        end else begin
          fdone = (c_q == m_eff);
          c_d = c_q - 6'd1;
          state_d = S_FIND_RD;
        end
      end
      S_FIND_CHK: begin
        if (mem_rdata) begin
          fhit = 1'b1;
          fdone = 1'b1;
          found_v_d = 1'b1;
          found_d = find_node;
          lg_d = c_q[4:0];
          mem_we = 1'b1;
          mem_waddr = find_node;
        end else begin
          fdone = (c_q == m_eff);
          c_d = c_q - 6'd1;
          state_d = S_FIND_RD;
        end
      end
      S_ALLOC: begin
        start_d = NODE_W'(1) << (h_eff - k_q);
        cur_d = NODE_W'(1) << (h_eff - k_q);
        anc_d = (NODE_W'(1) << (h_eff - k_q)) >> 1;
        first_v_d = 1'b0;
        state_d = S_ANC_RD;
      end
      // ancestors of the candidate
      S_ANC_RD: begin
        mem_raddr = anc_q;
        if (anc_q == '0) begin
          base_d = cur_q; t_d = '0; j_d = '0; buddy_d = 1'b0;
          state_d = S_SUB_RD;
        end else begin
          state_d = S_ANC_CHK;
        end
      end
      S_ANC_CHK: begin
        if (mem_rdata) begin
          state_d = S_NEXT;
        end else begin
          anc_d = anc_q >> 1;
          state_d = S_ANC_RD;
        end
      end
      // subtree of the candidate or of its buddy
      S_SUB_RD: begin
        mem_raddr = sub_addr;
        state_d = S_SUB_CHK;
      end
      S_SUB_CHK: begin
        state_d = S_SUB_RD;
        if (mem_rdata) begin
          if (buddy_q) begin
            succ = 1'b1;
            pick = cur_q;
          end else begin
            state_d = S_NEXT;
          end
        end else if (j_q == sub_last) begin
          if (t_q == times) begin
            if (!buddy_q) begin
              if (!first_v_q) begin
                first_v_d = 1'b1;
                first_d = cur_q;
              end
              if (cur_q != NODE_W'(1)) begin
                base_d = cur_q ^ NODE_W'(1); t_d = '0; j_d = '0; buddy_d = 1'b1;
              end else begin
                state_d = S_NEXT;
              end
            end else begin
              state_d = S_NEXT;
            end
          end else begin
            t_d = t_q + LVL_W'(1);
            j_d = '0;
          end
        end else begin
          j_d = j_q + NODE_W'(1);
        end
      end
      S_NEXT: begin
        if (cur_q == ((start_q << 1) - NODE_W'(1))) begin
          if (first_v_q) begin
            succ = 1'b1;
            pick = first_q;
          end else begin
            afail = 1'b1;
          end
        end else begin
          cur_d = cur_q + NODE_W'(1);
          anc_d = (cur_q + NODE_W'(1)) >> 1;
          state_d = S_ANC_RD;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase

    // end of the find walk
    if (fdone) begin
      state_d = S_DONE;
      if (op_q == OP_FREE) begin
        res_d.status = fhit ? ST_NO_OFFSET : ST_FAIL;
      end else if (size_q == 32'd0) begin
        res_d.status = ST_NO_OFFSET;
      end else begin
        state_d = S_ALLOC;
      end
    end

    // allocation taken
    if (succ) begin
      mem_we = 1'b1;
      mem_waddr = pick;
      mem_wdata = 1'b1;
      roff = 32'(pick - start_q) << k_q[4:0];
      res_d.status = ST_OFFSET;
      res_d.result_offset = roff[30:0];
      res_d.old_block_size = (op_q == OP_REALLOC && found_v_q) ? (32'd1 << lg_q) : 32'd0;
      state_d = S_DONE;
    end

    // allocation failed, restore a freed block
    if (afail) begin
      if (op_q == OP_REALLOC && found_v_q) begin
        mem_we = 1'b1;
        mem_waddr = found_q;
        mem_wdata = 1'b1;
      end
      res_d.status = ST_FAIL;
      state_d = S_DONE;
    end

    // config transfer rewrites a register and clears the tree
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_HEAP_LOG2) begin
        heap_d = cfg_data_i[4:0];
        state_d = S_CLEAR;
        clr_d = '0;
      end else if (cfg_index_i == CFG_MIN_LOG2) begin
        min_d = cfg_data_i[4:0];
        state_d = S_CLEAR;
        clr_d = '0;
      end
    end
  end

  // port outputs
  always_comb begin
    busy = (state_q != S_IDLE);
    done_o = (state_q == S_DONE);
    res_o = res_q;
    cfg_ready_o = 1'b1;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      heap_q <= HEAP_LOG2_RST;
      min_q <= MIN_LOG2_RST;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      heap_q <= heap_d;
      min_q <= min_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    op_q <= op_d; size_q <= size_d; off_q <= off_d; pres_q <= pres_d; v_q <= v_d;
    k_q <= k_d; c_q <= c_d; found_v_q <= found_v_d; found_q <= found_d; lg_q <= lg_d;
    start_q <= start_d; cur_q <= cur_d; anc_q <= anc_d; first_v_q <= first_v_d;
    first_q <= first_d; base_q <= base_d; j_q <= j_d; t_q <= t_d; buddy_q <= buddy_d;
    res_q <= res_d;
  end

endmodule

[sv/bta_ram.sv]
// bta_ram: generic single write, single read RAM with registered read
// no dependencies

module bta_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/bta_checker.sv]
// bta_checker: port level checks on the buddy allocator tree bitmap
// depends on bta_pkg, bound to buddy_allocator_tree_bitmap

module bta_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          done_o,
  input bta_pkg::res_t res_o
);

  import bta_pkg::*;

  // an accepted transfer holds the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted item did not raise busy");

  // result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  // result only while an item is in hand
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result outside an item");

  // only an allocation carries an offset
  a_no_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && res_o.status != ST_OFFSET |-> res_o.result_offset == '0)
    else $error("offset on a result without allocation");

  // status code is a known one
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> res_o.status == ST_OFFSET || res_o.status == ST_FAIL ||
               res_o.status == ST_NO_OFFSET) else $error("unknown status");

endmodule

bind buddy_allocator_tree_bitmap bta_checker u_bta_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);
